// ===== rtl/rpv_pkg.sv =====
// shared types, widths and constants for the vertex rotate and project block
`default_nettype none

package rpv_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 128;
  localparam int HALF_W = SCREEN_WIDTH / 2;
  localparam int HALF_H = SCREEN_HEIGHT / 2;

  // fixed point
  localparam int FRAC      = 14;
  localparam int COS_ONE   = 16384;
  localparam int DEPTH_MIN = 1638;
  localparam int VD_RST    = 60;
  localparam int SCALE_RST = 90;
  localparam int SAT_MAX   = 32767;
  localparam int SAT_MIN   = -32768;

  // port widths
  localparam int VW     = 8;
  localparam int TRIG_W = 16;
  localparam int PAR_W  = 8;
  localparam int SCR_W  = 16;
  localparam int CFG_IW = 3;

  // datapath widths
  localparam int P1W = VW + TRIG_W;        // integer coordinate times factor
  localparam int Y1W = P1W + 1;            // first rotation
  localparam int P3W = Y1W + TRIG_W;       // second rotation products
  localparam int X2W = 26;                 // second rotation result
  localparam int P5W = X2W + TRIG_W;       // third rotation products
  localparam int X3W = 28;                 // rotated x and y
  localparam int DW  = 27;                 // depth
  localparam int NW  = X3W + PAR_W + 1;    // coordinate times scale
  localparam int MW  = NW - 1;             // numerator magnitude
  localparam int QB  = 17;                 // quotient bits below the clamp
  localparam int CW  = DW + QB;            // divider compare width
  localparam int SW  = QB + 3;             // screen sum before saturation

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FPW = $clog2(FIFO_DEPTH);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IW-1:0] {
    IDX_SIN_X = 3'd0,
    IDX_COS_X = 3'd1,
    IDX_SIN_Y = 3'd2,
    IDX_COS_Y = 3'd3,
    IDX_SIN_Z = 3'd4,
    IDX_COS_Z = 3'd5,
    IDX_DIST  = 3'd6,
    IDX_SCALE = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_z;
    logic signed [TRIG_W-1:0] cos_z;
    logic [PAR_W-1:0]         view_distance;
    logic [PAR_W-1:0]         proj_scale;
  } cfg_t;

  // rotated vertex handed from front to back
  typedef struct packed {
    logic signed [X3W-1:0] x3;
    logic signed [X3W-1:0] y3;
    logic signed [DW-1:0]  depth;
  } rot_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rpv_front.sv =====
// front end: accepts vertex words and runs the three rotations and the depth add
`default_nettype none

module rpv_front import rpv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [3*VW-1:0]   in_tdata,
  input  wire fifo_stat_t        fstat,
  output logic                   push,
  output rot_t                   item
);

  logic signed [VW-1:0] vx, vy, vz;
  logic en;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  logic signed [P1W-1:0] p_ycx_r, p_zsx_r, p_ysx_r, p_zcx_r, p_xcy_r, p_xsy_r;
  logic signed [P1W-1:0] p_ycx_nxt, p_zsx_nxt, p_ysx_nxt, p_zcx_nxt, p_xcy_nxt, p_xsy_nxt;

  logic signed [Y1W-1:0] y1_r, z1_r, y1_3_r, y1_4_r;
  logic signed [Y1W-1:0] y1_nxt, z1_nxt;
  logic signed [P1W-1:0] xcy2_r, xsy2_r, xcy3_r, xsy3_r;

  logic signed [P3W-1:0] p_zsy_r, p_zcy_r, p_zsy_nxt, p_zcy_nxt;

  logic signed [X2W-1:0] x2_r, z2_r, z2_5_r, x2_nxt, z2_nxt;

  logic signed [P5W-1:0] p_xcz_r, p_ysz_r, p_xsz_r, p_ycz_r;
  logic signed [P5W-1:0] p_xcz_nxt, p_ysz_nxt, p_xsz_nxt, p_ycz_nxt;

  logic signed [P5W:0]   dx, dy;
  logic signed [DW-1:0]  vd_q, dep;
  rot_t                  item_r, item_nxt;

  assign vx = $signed(in_tdata[VW-1:0]);
  assign vy = $signed(in_tdata[2*VW-1:VW]);
  assign vz = $signed(in_tdata[3*VW-1:2*VW]);

  // whole front advances unless its last stage is blocked by a full queue
  assign en        = !v6_r || !fstat.full;
  assign in_tready = en;
  assign push      = en && v6_r;
  assign item      = item_r;

  always_comb begin
    p_ycx_nxt = vy * $signed(cfg.cos_x);
    p_zsx_nxt = vz * $signed(cfg.sin_x);
    p_ysx_nxt = vy * $signed(cfg.sin_x);
    p_zcx_nxt = vz * $signed(cfg.cos_x);
    p_xcy_nxt = vx * $signed(cfg.cos_y);
    p_xsy_nxt = vx * $signed(cfg.sin_y);

    y1_nxt = Y1W'(p_ycx_r) - Y1W'(p_zsx_r);
    z1_nxt = Y1W'(p_ysx_r) + Y1W'(p_zcx_r);

    p_zsy_nxt = z1_r * $signed(cfg.sin_y);
    p_zcy_nxt = z1_r * $signed(cfg.cos_y);

    // arithmetic shift floors back to q.14
    x2_nxt = X2W'(xcy3_r) + X2W'(p_zsy_r >>> FRAC);
    z2_nxt = X2W'(p_zcy_r >>> FRAC) - X2W'(xsy3_r);

    p_xcz_nxt = x2_r * $signed(cfg.cos_z);
    p_ysz_nxt = y1_4_r * $signed(cfg.sin_z);
    p_xsz_nxt = x2_r * $signed(cfg.sin_z);
    p_ycz_nxt = y1_4_r * $signed(cfg.cos_z);

    dx = (P5W+1)'(p_xcz_r) - (P5W+1)'(p_ysz_r);
    dy = (P5W+1)'(p_xsz_r) + (P5W+1)'(p_ycz_r);

    vd_q = DW'({cfg.view_distance, {FRAC{1'b0}}});
    dep  = DW'(z2_5_r) + vd_q;
    if (dep == '0) begin
      dep = DW'(DEPTH_MIN);
    end

    item_nxt.x3    = dx[X3W+FRAC-1:FRAC];
    item_nxt.y3    = dy[X3W+FRAC-1:FRAC];
    item_nxt.depth = dep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ycx_r <= p_ycx_nxt;
      p_zsx_r <= p_zsx_nxt;
      p_ysx_r <= p_ysx_nxt;
      p_zcx_r <= p_zcx_nxt;
      p_xcy_r <= p_xcy_nxt;
      p_xsy_r <= p_xsy_nxt;

      y1_r   <= y1_nxt;
      z1_r   <= z1_nxt;
      xcy2_r <= p_xcy_r;
      xsy2_r <= p_xsy_r;

      p_zsy_r <= p_zsy_nxt;
      p_zcy_r <= p_zcy_nxt;
      xcy3_r  <= xcy2_r;
      xsy3_r  <= xsy2_r;
      y1_3_r  <= y1_r;

      x2_r   <= x2_nxt;
      z2_r   <= z2_nxt;
      y1_4_r <= y1_3_r;

      p_xcz_r <= p_xcz_nxt;
      p_ysz_r <= p_ysz_nxt;
      p_xsz_r <= p_xsz_nxt;
      p_ycz_r <= p_ycz_nxt;
      z2_5_r  <= z2_r;

      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpv_fifo.sv =====
// short queue of rotated vertices between front and back
`default_nettype none

module rpv_fifo import rpv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire rot_t  item_in,
  input  wire logic  pop,
  output rot_t       item_out,
  output fifo_stat_t stat
);

  rot_t             mem_r [FIFO_DEPTH];
  logic [FPW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0]   cnt_r;

  assign stat.full  = (cnt_r == FCW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign item_out   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FPW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FPW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpv_back.sv =====
// back end: scale, pipelined divide by depth, offset and saturate, output register
`default_nettype none

module rpv_back import rpv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire rot_t              item,
  input  wire fifo_stat_t        fstat,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [2*SCR_W-1:0]     out_tdata
);

  typedef struct packed {
    logic [MW-1:0] rem_x;
    logic [MW-1:0] rem_y;
    logic [QB-1:0] q_x;
    logic [QB-1:0] q_y;
    logic [DW-1:0] dmag;
    logic          sgn_x;
    logic          sgn_y;
    logic          ovf_x;
    logic          ovf_y;
  } div_t;

  // one restoring step on both lanes for quotient bit sh
  function automatic div_t div_step(input div_t s, input int unsigned sh);
    div_t o;
    logic [CW-1:0] dsh, rx, ry;
    o   = s;
    dsh = CW'(s.dmag) << sh;
    rx  = CW'(s.rem_x);
    ry  = CW'(s.rem_y);
    if (rx >= dsh) begin
      o.rem_x = MW'(rx - dsh);
      o.q_x   = s.q_x | (QB'(1) << sh);
    end
    if (ry >= dsh) begin
      o.rem_y = MW'(ry - dsh);
      o.q_y   = s.q_y | (QB'(1) << sh);
    end
    return o;
  endfunction

  function automatic logic [SCR_W-1:0] finish(input logic ovf, input logic sgn,
                                              input logic [QB-1:0] q,
                                              input logic signed [SW-1:0] half);
    logic signed [QB:0]   qs;
    logic signed [SW-1:0] sum;
    logic [SCR_W-1:0]     r;
    qs  = sgn ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum = SW'(qs) + half;
    if (ovf) begin
      r = sgn ? SCR_W'(SAT_MIN) : SCR_W'(SAT_MAX);
    end else if (sum > SW'(SAT_MAX)) begin
      r = SCR_W'(SAT_MAX);
    end else if (sum < SW'(SAT_MIN)) begin
      r = SCR_W'(SAT_MIN);
    end else begin
      r = sum[SCR_W-1:0];
    end
    return r;
  endfunction

  logic en;

  logic                 b1_v_r, b2_v_r;
  logic signed [NW-1:0] num_x_r, num_y_r, num_x_nxt, num_y_nxt;
  logic signed [DW-1:0] dep_b1_r;

  logic signed [NW-1:0] abs_x, abs_y;
  logic signed [DW-1:0] abs_d;
  logic [MW-1:0]        mag_x_r, mag_y_r;
  logic [DW-1:0]        mag_d_r;
  logic                 sgn_x_r, sgn_y_r;

  div_t dv_r   [QB+1];
  div_t dv_nxt [QB+1];
  logic dv_v_r [QB+1];

  logic              out_valid_r;
  logic [SCR_W-1:0]  out_sx_r, out_sy_r, out_sx_nxt, out_sy_nxt;

  // back half stalls only on the output register
  assign en         = !out_valid_r || out_tready;
  assign pop        = en && !fstat.empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sy_r, out_sx_r};

  always_comb begin
    num_x_nxt = item.x3 * $signed({1'b0, cfg.proj_scale});
    num_y_nxt = item.y3 * $signed({1'b0, cfg.proj_scale});

    abs_x = num_x_r[NW-1] ? -num_x_r : num_x_r;
    abs_y = num_y_r[NW-1] ? -num_y_r : num_y_r;
    abs_d = dep_b1_r[DW-1] ? -dep_b1_r : dep_b1_r;

    // quotients of 2^17 or more saturate whatever the offset
    dv_nxt[0].rem_x = mag_x_r;
    dv_nxt[0].rem_y = mag_y_r;
    dv_nxt[0].q_x   = '0;
    dv_nxt[0].q_y   = '0;
    dv_nxt[0].dmag  = mag_d_r;
    dv_nxt[0].sgn_x = sgn_x_r;
    dv_nxt[0].sgn_y = sgn_y_r;
    dv_nxt[0].ovf_x = CW'(mag_x_r) >= {mag_d_r, {QB{1'b0}}};
    dv_nxt[0].ovf_y = CW'(mag_y_r) >= {mag_d_r, {QB{1'b0}}};

    for (int k = 0; k < QB; k++) begin
      dv_nxt[k+1] = div_step(dv_r[k], QB - 1 - k);
    end

    out_sx_nxt = finish(dv_r[QB].ovf_x, dv_r[QB].sgn_x, dv_r[QB].q_x, SW'(HALF_W));
    out_sy_nxt = finish(dv_r[QB].ovf_y, dv_r[QB].sgn_y, dv_r[QB].q_y, SW'(HALF_H));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= QB; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      b1_v_r    <= !fstat.empty;
      b2_v_r    <= b1_v_r;
      dv_v_r[0] <= b2_v_r;
      for (int k = 0; k < QB; k++) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      out_valid_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x_r  <= num_x_nxt;
      num_y_r  <= num_y_nxt;
      dep_b1_r <= item.depth;

      mag_x_r <= abs_x[MW-1:0];
      mag_y_r <= abs_y[MW-1:0];
      mag_d_r <= abs_d;
      sgn_x_r <= num_x_r[NW-1] ^ dep_b1_r[DW-1];
      sgn_y_r <= num_y_r[NW-1] ^ dep_b1_r[DW-1];

      for (int k = 0; k <= QB; k++) begin
        dv_r[k] <= dv_nxt[k];
      end

      out_sx_r <= out_sx_nxt;
      out_sy_r <= out_sy_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rotate_project_vertex.sv =====
// top level: configuration registers, rotation front, queue and projection back
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready    tdata: vert_x, vert_y, vert_z (8 bits each)
//  out_     master     out_tvalid/out_tready  tdata: screen_x, screen_y (16 bits each)
//  cfg_     slave      cfg_valid/cfg_ready    cfg_index (3 bits), cfg_data (16 bits)
//
//  one vertex word per cycle sustained while out_tready is high; a word passes from input
//  to output through the six rotation stages and the 17-stage restoring divider
//  synchronous active-low reset clears all valid bits and the queue and loads the
//  register defaults (no rotation, distance 60, scale 90)
//  when out_tready is low the back half holds; the four-word queue absorbs the
//  front half, and in_tready drops once the queue is full and the front is blocked
`default_nettype none

module rotate_project_vertex import rpv_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [3*VW-1:0]      in_tdata,     // vert_x, vert_y, vert_z
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [2*SCR_W-1:0]        out_tdata,    // screen_x, screen_y
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IW-1:0]    cfg_index,
  input  wire logic [TRIG_W-1:0]    cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  rot_t       f_item, b_item;
  fifo_stat_t fstat;
  logic       push, pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        IDX_SIN_X: cfg_nxt.sin_x = cfg_data;
        IDX_COS_X: cfg_nxt.cos_x = cfg_data;
        IDX_SIN_Y: cfg_nxt.sin_y = cfg_data;
        IDX_COS_Y: cfg_nxt.cos_y = cfg_data;
        IDX_SIN_Z: cfg_nxt.sin_z = cfg_data;
        IDX_COS_Z: cfg_nxt.cos_z = cfg_data;
        IDX_DIST:  cfg_nxt.view_distance = cfg_data[PAR_W-1:0];
        IDX_SCALE: cfg_nxt.proj_scale = cfg_data[PAR_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sin_x         <= '0;
      cfg_r.cos_x         <= TRIG_W'(COS_ONE);
      cfg_r.sin_y         <= '0;
      cfg_r.cos_y         <= TRIG_W'(COS_ONE);
      cfg_r.sin_z         <= '0;
      cfg_r.cos_z         <= TRIG_W'(COS_ONE);
      cfg_r.view_distance <= PAR_W'(VD_RST);
      cfg_r.proj_scale    <= PAR_W'(SCALE_RST);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rpv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .fstat     (fstat),
    .push      (push),
    .item      (f_item)
  );

  rpv_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_in  (f_item),
    .pop      (pop),
    .item_out (b_item),
    .stat     (fstat)
  );

  rpv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (b_item),
    .fstat      (fstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
